// ===== rtl/rtkf_pkg.sv =====
package rtkf_pkg;

  localparam int KEY_FIELDS = 4;
  localparam int DEF_MAX_KEYS = 4;
  localparam int DEF_MAX_KEEP = 64;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  // Register indexes of the configuration port
  localparam logic [7:0] REG_KEEP_COUNT = 8'd0;
  localparam logic [7:0] REG_KEY_COLUMNS = 8'd1;
  localparam logic [7:0] REG_KEY_KINDS = 8'd2;
  localparam logic [7:0] REG_DESC_MASK = 8'd3;

  localparam logic [1:0] KIND_SIGNED = 2'd0;
  localparam logic [1:0] KIND_UNSIGNED = 2'd1;
  localparam logic [1:0] KIND_FLOAT32 = 2'd2;
  localparam logic [1:0] KIND_FLOAT64 = 2'd3;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic scan_cmp;
    logic decide;
    logic shift_rd;
    logic shift_wr;
    logic place;
  } ctl_cmd_t;

  typedef struct packed {
    logic keep_row;
    logic room;
    logic scan_last;
    logic evict;
    logic shift_end;
  } ctl_sts_t;

  typedef logic [KEY_FIELDS-1:0][63:0] key_set_t;

  function automatic cmp_t cmp_u(input logic [63:0] a, input logic [63:0] b);
    cmp_t r;
    if (a > b) r = CMP_GT;
    else if (a < b) r = CMP_LT;
    else r = CMP_EQ;
    return r;
  endfunction

  function automatic logic [63:0] float_ord(input logic [63:0] bits, input logic wide,
                                            output logic nan);
    logic sign;
    logic [63:0] mag;
    if (wide) begin
      sign = bits[63];
      mag = {1'b0, bits[62:0]};
      nan = mag > 64'h7FF0_0000_0000_0000;
    end else begin
      sign = bits[31];
      mag = {33'd0, bits[30:0]};
      nan = mag > 64'h0000_0000_7F80_0000;
    end
    return sign ? (SIGN64 - mag) : (SIGN64 + mag);
  endfunction

  function automatic cmp_t cmp_field(input logic [1:0] kind, input logic an,
                                     input logic [63:0] av, input logic bn,
                                     input logic [63:0] bv);
    cmp_t r;
    logic anan, bnan;
    logic [63:0] ao, bo;
    anan = 1'b0;
    bnan = 1'b0;
    ao = float_ord(av, kind == KIND_FLOAT64, anan);
    bo = float_ord(bv, kind == KIND_FLOAT64, bnan);
    if (an || bn) begin
      if (an && bn) r = CMP_EQ;
      else r = an ? CMP_LT : CMP_GT;
    end else begin
      case (kind)
        KIND_SIGNED: r = cmp_u(av ^ SIGN64, bv ^ SIGN64);
        KIND_UNSIGNED: r = cmp_u(av, bv);
        default: begin
          if (anan && bnan) r = CMP_EQ;
          else if (anan) r = CMP_LT;
          else if (bnan) r = CMP_GT;
          else r = cmp_u(ao, bo);
        end
      endcase
    end
    return r;
  endfunction

  // Directed lexicographic order over the first nk keys
  function automatic cmp_t cmp_keys(input key_set_t ak, input logic [3:0] an,
                                    input key_set_t bk, input logic [3:0] bn,
                                    input logic [2:0] nk, input logic [7:0] kinds,
                                    input logic [3:0] desc);
    cmp_t r, c;
    r = CMP_EQ;
    for (int i = 0; i < KEY_FIELDS; i++) begin
      c = cmp_field(kinds[2*i +: 2], an[i], ak[i], bn[i], bk[i]);
      if (r == CMP_EQ && 3'(i) < nk && c != CMP_EQ) begin
        if (desc[i]) r = (c == CMP_LT) ? CMP_GT : CMP_LT;
        else r = c;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/rtkf_ctrl.sv =====
module rtkf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rtkf_pkg::ctl_sts_t sts,
  output rtkf_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  rtkf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rtkf_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rtkf_pkg::ST_IDLE: begin
        if (start) begin
          if (!sts.keep_row) state_next = rtkf_pkg::ST_DONE;
          else if (sts.room) state_next = rtkf_pkg::ST_PLACE;
          else state_next = rtkf_pkg::ST_SCAN_RD;
        end
      end
      rtkf_pkg::ST_SCAN_RD: state_next = rtkf_pkg::ST_SCAN_CMP;
      rtkf_pkg::ST_SCAN_CMP: begin
        state_next = sts.scan_last ? rtkf_pkg::ST_DECIDE : rtkf_pkg::ST_SCAN_RD;
      end
      rtkf_pkg::ST_DECIDE: begin
        state_next = sts.evict ? rtkf_pkg::ST_SHIFT_RD : rtkf_pkg::ST_DONE;
      end
      rtkf_pkg::ST_SHIFT_RD: begin
        state_next = sts.shift_end ? rtkf_pkg::ST_PLACE : rtkf_pkg::ST_SHIFT_WR;
      end
      rtkf_pkg::ST_SHIFT_WR: state_next = rtkf_pkg::ST_SHIFT_RD;
      rtkf_pkg::ST_PLACE: state_next = rtkf_pkg::ST_DONE;
      rtkf_pkg::ST_DONE: state_next = rtkf_pkg::ST_IDLE;
      default: state_next = rtkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      rtkf_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.accept = start;
      end
      rtkf_pkg::ST_SCAN_RD: cmd.scan_rd = 1'b1;
      rtkf_pkg::ST_SCAN_CMP: cmd.scan_cmp = 1'b1;
      rtkf_pkg::ST_DECIDE: cmd.decide = 1'b1;
      rtkf_pkg::ST_SHIFT_RD: cmd.shift_rd = 1'b1;
      rtkf_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      rtkf_pkg::ST_PLACE: cmd.place = 1'b1;
      rtkf_pkg::ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> busy) else $error("busy not raised after accept");
  a_scan_pairs: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |=> cmd.scan_cmp) else $error("scan read not followed by compare");

endmodule

// ===== rtl/rtkf_dp.sv =====
module rtkf_dp #(
  parameter int MAX_KEYS = rtkf_pkg::DEF_MAX_KEYS,
  parameter int MAX_KEEP = rtkf_pkg::DEF_MAX_KEEP
) (
  input  logic               clk,
  input  logic               rst,
  input  rtkf_pkg::ctl_cmd_t cmd,
  output rtkf_pkg::ctl_sts_t sts,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               new_block,
  input  logic               keep,
  input  logic [63:0]        key_a,
  input  logic [63:0]        key_b,
  input  logic [63:0]        key_c,
  input  logic [63:0]        key_d,
  input  logic [3:0]         null_flags,
  output logic               admitted,
  output logic [31:0]        row_number,
  output logic               evicted_valid,
  output logic               evicted_in_block,
  output logic [31:0]        evicted_row,
  output logic [6:0]         marked_rows
);

  localparam int SK = (MAX_KEYS < rtkf_pkg::KEY_FIELDS) ? MAX_KEYS : rtkf_pkg::KEY_FIELDS;
  localparam int IdxW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int FillW = $clog2(MAX_KEEP + 1);
  localparam int CmpW = (FillW > 7) ? FillW : 7;
  localparam int KeyW = SK * 64;
  localparam int EntW = KeyW + 4 + 32 + 32;
  localparam logic [2:0] KeyLim = 3'(SK);

  logic [6:0] keep_count;
  logic [2:0] key_columns;
  logic [7:0] key_kinds;
  logic [3:0] descending_mask;

  logic [FillW-1:0] fill_count;
  logic [31:0] block_tag;
  logic [31:0] row_counter;

  logic [KeyW-1:0] new_keys;
  logic [3:0] new_nulls;
  logic keep_row;

  logic [EntW-1:0] mem [MAX_KEEP];
  logic [EntW-1:0] rdata;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;
  logic we;

  logic [IdxW-1:0] scan_idx;
  logic [IdxW-1:0] shift_idx;
  logic [IdxW-1:0] worst_idx;
  logic [EntW-1:0] worst;
  logic evicting;

  logic [2:0] eff_keys;
  logic [CmpW-1:0] eff_keep;
  logic [FillW-1:0] last_idx;
  rtkf_pkg::key_set_t rd_set, worst_set, new_set;
  rtkf_pkg::cmp_t scan_cmp, new_cmp;
  logic [KeyW-1:0] in_keys;
  logic [rtkf_pkg::KEY_FIELDS-1:0][63:0] in_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= 7'd1;
      key_columns <= 3'd1;
      key_kinds <= '0;
      descending_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtkf_pkg::REG_KEEP_COUNT: keep_count <= cfg_data[6:0];
        rtkf_pkg::REG_KEY_COLUMNS: key_columns <= cfg_data[2:0];
        rtkf_pkg::REG_KEY_KINDS: key_kinds <= cfg_data;
        rtkf_pkg::REG_DESC_MASK: descending_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_columns == 3'd0) eff_keys = 3'd1;
    else if (key_columns > KeyLim) eff_keys = KeyLim;
    else eff_keys = key_columns;
    if (keep_count == 7'd0) eff_keep = CmpW'(1);
    else if (CmpW'(keep_count) > CmpW'(MAX_KEEP)) eff_keep = CmpW'(MAX_KEEP);
    else eff_keep = CmpW'(keep_count);
    last_idx = fill_count - FillW'(1);
  end

  always_comb begin
    in_raw = {key_d, key_c, key_b, key_a};
    for (int i = 0; i < SK; i++) begin
      in_keys[i*64 +: 64] = null_flags[i] ? 64'd0 : in_raw[i];
    end
  end

  always_comb begin
    for (int i = 0; i < rtkf_pkg::KEY_FIELDS; i++) begin
      if (i < SK) begin
        rd_set[i] = rdata[(i % SK)*64 +: 64];
        worst_set[i] = worst[(i % SK)*64 +: 64];
        new_set[i] = new_keys[(i % SK)*64 +: 64];
      end else begin
        rd_set[i] = '0;
        worst_set[i] = '0;
        new_set[i] = '0;
      end
    end
    scan_cmp = rtkf_pkg::cmp_keys(rd_set, rdata[KeyW +: 4], worst_set, worst[KeyW +: 4],
                                  eff_keys, key_kinds, descending_mask);
    new_cmp = rtkf_pkg::cmp_keys(new_set, new_nulls, worst_set, worst[KeyW +: 4],
                                 eff_keys, key_kinds, descending_mask);
  end

  always_comb begin
    sts.keep_row = keep;
    sts.room = CmpW'(fill_count) < eff_keep;
    sts.scan_last = FillW'(scan_idx) == last_idx;
    sts.evict = new_cmp == rtkf_pkg::CMP_LT;
    sts.shift_end = FillW'(shift_idx) == last_idx;
  end

  // Memory port steering
  always_comb begin
    rd_addr = cmd.shift_rd ? (shift_idx + IdxW'(1)) : scan_idx;
    we = cmd.shift_wr || cmd.place;
    if (cmd.shift_wr) begin
      wr_addr = shift_idx;
      wr_data = rdata;
    end else begin
      wr_addr = evicting ? last_idx[IdxW-1:0] : fill_count[IdxW-1:0];
      wr_data = {row_number, block_tag, new_nulls, new_keys};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      block_tag <= '0;
      row_counter <= '0;
      marked_rows <= '0;
      evicting <= 1'b0;
    end else begin
      if (cmd.accept) begin
        evicting <= 1'b0;
        if (new_block) begin
          block_tag <= block_tag + 32'd1;
          row_counter <= 32'd1;
          marked_rows <= '0;
        end else begin
          row_counter <= row_counter + 32'd1;
        end
      end
      if (cmd.decide && sts.evict) begin
        evicting <= 1'b1;
        if (worst[KeyW+4 +: 32] == block_tag && marked_rows != 7'd0) begin
          marked_rows <= marked_rows - 7'd1;
        end
      end
      if (cmd.place) begin
        if (!evicting) fill_count <= fill_count + FillW'(1);
        if (marked_rows != 7'd127) marked_rows <= marked_rows + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_keys <= in_keys;
      new_nulls <= null_flags;
      keep_row <= keep;
      row_number <= new_block ? 32'd0 : row_counter;
      admitted <= 1'b0;
      evicted_valid <= 1'b0;
      evicted_in_block <= 1'b0;
      evicted_row <= '0;
      scan_idx <= '0;
    end
    if (cmd.scan_cmp) begin
      if (scan_idx == '0 || scan_cmp != rtkf_pkg::CMP_LT) begin
        worst <= rdata;
        worst_idx <= scan_idx;
      end
      scan_idx <= scan_idx + IdxW'(1);
    end
    if (cmd.decide && sts.evict) begin
      evicted_valid <= 1'b1;
      evicted_in_block <= worst[KeyW+4 +: 32] == block_tag;
      evicted_row <= worst[KeyW+36 +: 32];
      shift_idx <= worst_idx;
    end
    if (cmd.shift_wr) shift_idx <= shift_idx + IdxW'(1);
    if (cmd.place) admitted <= keep_row;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillW'(MAX_KEEP)) else $error("store overfilled");
  a_fill_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill_count >= $past(fill_count)) else $error("store shrank");
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place && evicting |-> fill_count != '0) else $error("eviction from empty store");

endmodule

// ===== rtl/running_topk_row_filter.sv =====
// Running top-k row filter. Pulse start with a row while busy is low; the row is
// taken at that edge and one result comes back later on the result ports,
// marked by done for exactly one cycle, which the receiver must capture since
// it cannot stall. A skipped row goes straight to the result, and a kept row
// while the store has room is placed first. Once the store is full, the entry
// memory (one read and one write port) is walked entry by entry, each read then
// compared, to find the worst entry; a rejected row then gives its result, and
// an admitted row first has the entries above the evicted one slide down one
// place to keep insertion order and is then placed. Busy stays high until the
// result cycle ends, so the next row can be taken in the cycle after the result.
// Configuration is written through cfg_valid/cfg_ready (always ready); the user
// must do so only while no transaction is in flight; the block does not check it.
module running_topk_row_filter #(
  parameter int MAX_KEYS = rtkf_pkg::DEF_MAX_KEYS,
  parameter int MAX_KEEP = rtkf_pkg::DEF_MAX_KEEP
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        new_block,
  input  logic        keep,
  input  logic [63:0] key_a,
  input  logic [63:0] key_b,
  input  logic [63:0] key_c,
  input  logic [63:0] key_d,
  input  logic [3:0]  null_flags,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic        admitted,
  output logic [31:0] row_number,
  output logic        evicted_valid,
  output logic        evicted_in_block,
  output logic [31:0] evicted_row,
  output logic [6:0]  marked_rows
);

  rtkf_pkg::ctl_cmd_t cmd;
  rtkf_pkg::ctl_sts_t sts;

  // Registers take writes on any cycle
  assign cfg_ready = 1'b1;

  rtkf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rtkf_dp #(
    .MAX_KEYS (MAX_KEYS),
    .MAX_KEEP (MAX_KEEP)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .new_block        (new_block),
    .keep             (keep),
    .key_a            (key_a),
    .key_b            (key_b),
    .key_c            (key_c),
    .key_d            (key_d),
    .null_flags       (null_flags),
    .admitted         (admitted),
    .row_number       (row_number),
    .evicted_valid    (evicted_valid),
    .evicted_in_block (evicted_in_block),
    .evicted_row      (evicted_row),
    .marked_rows      (marked_rows)
  );

  a_evict_admits: assert property (@(posedge clk) disable iff (rst)
    done && evicted_valid |-> admitted) else $error("eviction without admission");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy low right after a transaction");
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");

endmodule
